// ===== rtl/core/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types, constants and codes of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned DefKeyBits  = 32;
  localparam int unsigned IdBits      = 10;
  localparam int unsigned IdCount     = 1 << IdBits;
  localparam int unsigned OutKeyBits  = 32;
  localparam int unsigned CountBits   = 11;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_DECREASE = 2'd2,
    ACT_PEEK     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_FULL     = 3'd1,
    ERR_EMPTY    = 3'd2,
    ERR_DUP      = 3'd3,
    ERR_ABSENT   = 3'd4,
    ERR_INCREASE = 3'd5
  } error_e;

endpackage

// ===== rtl/core/imhq_if.sv =====
// ----------------------------------------------------------------------------
// imhq_req_if / imhq_rsp_if
// Valid/ready channels carrying queue requests and their results.
// ----------------------------------------------------------------------------
interface imhq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  item_id;
  logic [31:0] new_key;
  modport source (output valid, action, item_id, new_key, input ready);
  modport sink   (input valid, action, item_id, new_key, output ready);
endinterface

interface imhq_rsp_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_id;
  logic [31:0] out_key;
  logic [10:0] item_count;
  logic        is_empty;
  logic [2:0]  error_code;
  modport source (output valid, out_id, out_key, item_count, is_empty, error_code,
                  input ready);
  modport sink   (input valid, out_id, out_key, item_count, is_empty, error_code,
                  output ready);
endinterface

// ===== rtl/core/indexed_min_heap_queue_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_unit
// Indexed binary min-heap priority queue with id-to-slot map.
// ----------------------------------------------------------------------------
// One request is handled at a time; each returns exactly one result. The id
// map holds a presence bit beside each heap slot, so after reset the block
// clears every entry of it before it takes the first request. Insert and
// decrease-key sift up through S_UPRD, S_UPCM and S_UPW at each heap level,
// delete sifts down through S_DNL, S_DNR, S_DNCM and S_UPW at each level,
// all bound by the single read port of the heap memory. Keys are unsigned
// 16.16 fixed point.
module indexed_min_heap_queue_unit
  import imhq_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity,
  parameter int unsigned KeyBits  = DefKeyBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  imhq_req_if.sink   req,
  imhq_rsp_if.source rsp
);

  localparam int unsigned SlotBits = $clog2(Capacity + 1);
  localparam int unsigned PosW     = SlotBits + 1;
  localparam int unsigned HeapW    = IdBits + KeyBits;

  logic                heap_we;
  logic [SlotBits-1:0] heap_waddr, heap_raddr;
  logic [HeapW-1:0]    heap_wdata, heap_rdata;
  logic                pos_we;
  logic [IdBits-1:0]   pos_waddr, pos_raddr;
  logic [PosW-1:0]     pos_wdata, pos_rdata;

  imhq_ctrl #(.Capacity(Capacity), .KeyBits(KeyBits)) u_ctrl (
    .clk_i, .rst_ni, .req, .rsp,
    .heap_we_o(heap_we), .heap_waddr_o(heap_waddr), .heap_wdata_o(heap_wdata),
    .heap_raddr_o(heap_raddr), .heap_rdata_i(heap_rdata),
    .pos_we_o(pos_we), .pos_waddr_o(pos_waddr), .pos_wdata_o(pos_wdata),
    .pos_raddr_o(pos_raddr), .pos_rdata_i(pos_rdata)
  );

  imhq_ram #(.Width(HeapW), .Depth(1 << SlotBits)) u_heap (
    .clk_i, .we_i(heap_we), .waddr_i(heap_waddr), .wdata_i(heap_wdata),
    .raddr_i(heap_raddr), .rdata_o(heap_rdata)
  );

  imhq_ram #(.Width(PosW), .Depth(IdCount)) u_pos (
    .clk_i, .we_i(pos_we), .waddr_i(pos_waddr), .wdata_i(pos_wdata),
    .raddr_i(pos_raddr), .rdata_o(pos_rdata)
  );

endmodule

// ===== rtl/core/imhq_ram.sv =====
// ----------------------------------------------------------------------------
// imhq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imhq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/imhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// imhq_ctrl
// Sequencer that runs one request through the heap and position memories.
// ----------------------------------------------------------------------------
module imhq_ctrl
  import imhq_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity,
  parameter int unsigned KeyBits  = DefKeyBits,
  localparam int unsigned SlotBits = $clog2(Capacity + 1),
  localparam int unsigned PosW     = SlotBits + 1,
  localparam int unsigned HeapW    = IdBits + KeyBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  imhq_req_if.sink            req,
  imhq_rsp_if.source          rsp,
  output logic                heap_we_o,
  output logic [SlotBits-1:0] heap_waddr_o,
  output logic [HeapW-1:0]    heap_wdata_o,
  output logic [SlotBits-1:0] heap_raddr_o,
  input  logic [HeapW-1:0]    heap_rdata_i,
  output logic                pos_we_o,
  output logic [IdBits-1:0]   pos_waddr_o,
  output logic [PosW-1:0]     pos_wdata_o,
  output logic [IdBits-1:0]   pos_raddr_o,
  input  logic [PosW-1:0]     pos_rdata_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POS  = 4'd1;
  localparam logic [3:0] S_DECK = 4'd2;
  localparam logic [3:0] S_UPRD = 4'd3;
  localparam logic [3:0] S_UPCM = 4'd4;
  localparam logic [3:0] S_DLST = 4'd5;
  localparam logic [3:0] S_DNL  = 4'd6;
  localparam logic [3:0] S_DNR  = 4'd7;
  localparam logic [3:0] S_DNCM = 4'd8;
  localparam logic [3:0] S_TOP  = 4'd9;
  localparam logic [3:0] S_TOPW = 4'd10;
  localparam logic [3:0] S_RSP  = 4'd11;
  localparam logic [3:0] S_DEL0 = 4'd12;
  localparam logic [3:0] S_UPW  = 4'd13;
  localparam logic [3:0] S_CLR  = 4'd14;

  localparam logic [SlotBits-1:0] SlotOne = SlotBits'(1);
  localparam logic [CountBits-1:0] CountCap = CountBits'(Capacity);
  localparam logic [IdBits-1:0] LastId = IdBits'(IdCount - 1);

  logic [3:0]            state_q, state_d;
  logic [SlotBits-1:0]   count_q, count_d;
  logic [SlotBits-1:0]   k_q, k_d, c_q, c_d;
  logic [IdBits-1:0]     id_q, id_d;
  logic [KeyBits-1:0]    key_q, key_d;
  logic [HeapW-1:0]      left_q, left_d;
  logic [HeapW-1:0]      other_q, other_d;
  logic [2:0]            err_q, err_d;
  logic [IdBits-1:0]     rid_q, rid_d;
  logic [KeyBits-1:0]    rkey_q, rkey_d;
  logic                  rep_q, rep_d;
  action_e               act_q, act_d;
  logic [IdBits-1:0]     clr_q, clr_d;

  logic [KeyBits-1:0]  rd_key;
  logic [IdBits-1:0]   rd_id;
  logic [KeyBits-1:0]  lkey;
  logic [SlotBits:0]   c2;
  logic                pos_hit;
  logic [SlotBits-1:0] pos_slot;

  assign rd_key   = heap_rdata_i[KeyBits-1:0];
  assign rd_id    = heap_rdata_i[HeapW-1:KeyBits];
  assign lkey     = left_q[KeyBits-1:0];
  assign c2       = {k_q, 1'b0};
  assign pos_hit  = pos_rdata_i[PosW-1];
  assign pos_slot = pos_rdata_i[SlotBits-1:0];

  assign req.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q; count_d = count_q;
    k_d = k_q; c_d = c_q; id_d = id_q; key_d = key_q;
    left_d = left_q; other_d = other_q; err_d = err_q;
    rid_d = rid_q; rkey_d = rkey_q; rep_d = rep_q;
    act_d = act_q; clr_d = clr_q;
    heap_we_o = 1'b0; heap_waddr_o = k_q; heap_wdata_o = {id_q, key_q};
    heap_raddr_o = SlotOne;
    pos_we_o = 1'b0; pos_waddr_o = id_q; pos_wdata_o = {1'b1, k_q};
    pos_raddr_o = req.item_id;
    unique case (state_q)
      S_CLR: begin
        pos_we_o = 1'b1;
        pos_waddr_o = clr_q;
        pos_wdata_o = '0;
        clr_d = clr_q + IdBits'(1);
        if (clr_q == LastId) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          id_d = req.item_id;
          key_d = KeyBits'(req.new_key);
          err_d = ERR_OK;
          rep_d = 1'b0;
          act_d = action_e'(req.action);
          unique case (action_e'(req.action))
            ACT_INSERT: begin
              if (CountBits'(count_q) >= CountCap) begin
                err_d = ERR_FULL; state_d = S_TOP;
              end else begin
                state_d = S_POS;
              end
            end
            ACT_DELETE: begin
              if (count_q == '0) begin
                err_d = ERR_EMPTY; state_d = S_TOP;
              end else begin
                state_d = S_DEL0;
              end
            end
            ACT_DECREASE: begin
              state_d = S_POS;
            end
            ACT_PEEK: begin
              if (count_q == '0) err_d = ERR_EMPTY;
              state_d = S_TOP;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_POS: begin
        if (act_q == ACT_INSERT) begin
          if (pos_hit) begin
            err_d = ERR_DUP; state_d = S_TOP;
          end else begin
            count_d = count_q + SlotOne;
            k_d = count_q + SlotOne;
            heap_we_o = 1'b1;
            heap_waddr_o = count_q + SlotOne;
            pos_we_o = 1'b1;
            pos_waddr_o = id_q;
            pos_wdata_o = {1'b1, count_q + SlotOne};
            state_d = S_UPRD;
          end
        end else if (!pos_hit) begin
          err_d = ERR_ABSENT; state_d = S_TOP;
        end else begin
          k_d = pos_slot;
          heap_raddr_o = pos_slot;
          state_d = S_DECK;
        end
      end
      S_DECK: begin
        if (key_q > rd_key) begin
          err_d = ERR_INCREASE; state_d = S_TOP;
        end else begin
          heap_we_o = 1'b1;
          state_d = S_UPRD;
        end
      end
      S_UPRD: begin
        if (k_q <= SlotOne) begin
          state_d = S_TOP;
        end else begin
          heap_raddr_o = k_q >> 1;
          state_d = S_UPCM;
        end
      end
      S_UPCM: begin
        if (rd_key > key_q) begin
          heap_we_o = 1'b1;
          heap_waddr_o = k_q;
          heap_wdata_o = heap_rdata_i;
          pos_we_o = 1'b1;
          pos_waddr_o = rd_id;
          pos_wdata_o = {1'b1, k_q};
          k_d = k_q >> 1;
          state_d = S_UPW;
        end else begin
          state_d = S_TOP;
        end
      end
      S_UPW: begin
        heap_we_o = 1'b1;
        pos_we_o = 1'b1;
        state_d = S_UPRD;
      end
      S_DEL0: begin
        state_d = S_DLST;
      end
      S_DLST: begin
        if (!rep_q) begin
          rid_d = rd_id; rkey_d = rd_key; rep_d = 1'b1;
          pos_we_o = 1'b1;
          pos_waddr_o = rd_id;
          pos_wdata_o = '0;
          heap_raddr_o = count_q;
          state_d = S_DLST;
        end else begin
          id_d = rd_id; key_d = rd_key;
          k_d = SlotOne;
          count_d = count_q - SlotOne;
          heap_we_o = 1'b1;
          heap_waddr_o = SlotOne;
          heap_wdata_o = heap_rdata_i;
          pos_we_o = (count_q != SlotOne);
          pos_waddr_o = rd_id;
          pos_wdata_o = {1'b1, SlotOne};
          state_d = S_DNL;
        end
      end
      S_DNL: begin
        if (c2 > {1'b0, count_q}) begin
          state_d = S_TOP;
        end else begin
          heap_raddr_o = SlotBits'(c2);
          c_d = SlotBits'(c2);
          state_d = S_DNR;
        end
      end
      S_DNR: begin
        left_d = heap_rdata_i;
        heap_raddr_o = c_q + SlotOne;
        state_d = S_DNCM;
      end
      S_DNCM: begin
        if (c_q < count_q && lkey > rd_key) begin
          other_d = heap_rdata_i;
          c_d = c_q + SlotOne;
        end else begin
          other_d = left_q;
        end
        if (c_q < count_q && lkey > rd_key) begin
          if (key_q > rd_key) begin
            heap_we_o = 1'b1;
            heap_waddr_o = k_q;
            heap_wdata_o = heap_rdata_i;
            pos_we_o = 1'b1;
            pos_waddr_o = rd_id;
            pos_wdata_o = {1'b1, k_q};
            k_d = c_q + SlotOne;
            state_d = S_UPW;
          end else begin
            state_d = S_TOP;
          end
        end else if (key_q > lkey) begin
          heap_we_o = 1'b1;
          heap_waddr_o = k_q;
          heap_wdata_o = left_q;
          pos_we_o = 1'b1;
          pos_waddr_o = left_q[HeapW-1:KeyBits];
          pos_wdata_o = {1'b1, k_q};
          k_d = c_q;
          state_d = S_UPW;
        end else begin
          state_d = S_TOP;
        end
        if (state_d == S_UPW) rep_d = 1'b1;
      end
      S_TOP: begin
        state_d = S_TOPW;
      end
      S_TOPW: begin
        if (!rep_q) begin
          rid_d = (count_q == '0) ? '0 : rd_id;
          rkey_d = (count_q == '0) ? '0 : rd_key;
        end
        state_d = S_RSP;
      end
      S_RSP: begin
        if (rsp.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // After a sift-down swap the write-back state returns to the down loop.
  logic down_q, down_d;
  assign down_d = (state_q == S_DLST) ? 1'b1 :
                  (state_q == S_IDLE) ? 1'b0 : down_q;

  logic [3:0] state_n;
  always_comb begin
    state_n = state_d;
    if (state_q == S_UPW && down_q) state_n = S_DNL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      count_q <= '0;
      down_q <= 1'b0;
      rep_q <= 1'b0;
    end else begin
      state_q <= state_n;
      clr_q <= clr_d;
      count_q <= count_d;
      down_q <= down_d;
      rep_q <= rep_d | (state_q == S_DLST) | down_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; c_q <= c_d; id_q <= id_d; key_q <= key_d;
    left_q <= left_d; other_q <= other_d; err_q <= err_d;
    rid_q <= rid_d; rkey_q <= rkey_d; act_q <= act_d;
  end

  assign rsp.valid      = (state_q == S_RSP);
  assign rsp.out_id     = rid_q;
  assign rsp.out_key    = OutKeyBits'(rkey_q);
  assign rsp.item_count = CountBits'(count_q);
  assign rsp.is_empty   = (count_q == '0);
  assign rsp.error_code = err_q;

  logic unused_other;
  assign unused_other = ^other_q;

endmodule

// ===== rtl/core/imhq_checker.sv =====
// ----------------------------------------------------------------------------
// imhq_checker
// Port-level checks of the queue's results, bound to the top level.
// ----------------------------------------------------------------------------
module imhq_checker
  import imhq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [10:0] item_count,
  input logic        is_empty,
  input logic [2:0]  error_code
);

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (is_empty == (item_count == 11'd0))) else $error("empty flag");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (error_code <= ERR_INCREASE)) else $error("bad error code");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(item_count))
    else $error("result dropped");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");

endmodule

bind indexed_min_heap_queue_unit imhq_checker u_imhq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .item_count(rsp.item_count), .is_empty(rsp.is_empty),
  .error_code(rsp.error_code)
);

// ===== tb/indexed_min_heap_queue_unit_test.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_unit_test
// Drives random and directed queue requests under varying back-pressure and
// compares every result with a behavioral heap kept alongside the block.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_unit_test;
  import imhq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class heap_scoreboard;
    logic [9:0]  slot_id  [1:1024];
    logic [31:0] slot_key [1:1024];
    int unsigned pos_of   [0:1023];
    bit          present  [0:1023];
    int unsigned held;
    logic [9:0]  q_id [$];
    logic [31:0] q_key [$];
    logic [10:0] q_cnt [$];
    logic        q_emp [$];
    error_e      q_err [$];
    int          errors;

    function new();
      held = 0;
      errors = 0;
      foreach (present[i]) present[i] = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [9:0]  ti;
      logic [31:0] tk;
      ti = slot_id[a];
      tk = slot_key[a];
      slot_id[a] = slot_id[b];
      slot_key[a] = slot_key[b];
      slot_id[b] = ti;
      slot_key[b] = tk;
      pos_of[slot_id[a]] = a;
      pos_of[slot_id[b]] = b;
    endfunction

    function void bubble_up(int unsigned k);
      while (k > 1 && slot_key[k / 2] > slot_key[k]) begin
        swap_slots(k, k / 2);
        k = k / 2;
      end
    endfunction

    function void bubble_down(int unsigned k);
      int unsigned c;
      while (2 * k <= held) begin
        c = 2 * k;
        if (c < held && slot_key[c] > slot_key[c + 1]) c++;
        if (!(slot_key[k] > slot_key[c])) break;
        swap_slots(k, c);
        k = c;
      end
    endfunction

    function void note_request(action_e act, logic [9:0] id, logic [31:0] key);
      error_e      err;
      logic [9:0]  rid;
      logic [31:0] rkey;
      bit          done;
      err = ERR_OK;
      rid = '0;
      rkey = '0;
      done = 0;
      case (act)
        ACT_INSERT: begin
          if (held >= 1024) err = ERR_FULL;
          else if (present[id]) err = ERR_DUP;
          else begin
            held++;
            slot_id[held] = id;
            slot_key[held] = key;
            pos_of[id] = held;
            present[id] = 1;
            bubble_up(held);
          end
        end
        ACT_DELETE: begin
          if (held == 0) err = ERR_EMPTY;
          else begin
            rid = slot_id[1];
            rkey = slot_key[1];
            done = 1;
            present[rid] = 0;
            slot_id[1] = slot_id[held];
            slot_key[1] = slot_key[held];
            pos_of[slot_id[1]] = 1;
            held--;
            if (held > 0) bubble_down(1);
          end
        end
        ACT_DECREASE: begin
          if (!present[id]) err = ERR_ABSENT;
          else if (key > slot_key[pos_of[id]]) err = ERR_INCREASE;
          else begin
            slot_key[pos_of[id]] = key;
            bubble_up(pos_of[id]);
          end
        end
        default: if (held == 0) err = ERR_EMPTY;
      endcase
      if (!done && held > 0) begin
        rid = slot_id[1];
        rkey = slot_key[1];
      end
      q_id.push_back(rid);
      q_key.push_back(rkey);
      q_cnt.push_back(held[10:0]);
      q_emp.push_back(held == 0);
      q_err.push_back(err);
    endfunction

    function void check_result(logic [9:0] id, logic [31:0] key, logic [10:0] cnt,
                               logic emp, logic [2:0] err);
      if (q_id.size() == 0) begin
        $display("%0t: unexpected result id=%0d key=%h", $time, id, key);
        errors++;
        return;
      end
      if (id !== q_id[0]) begin
        $display("%0t: out_id expected %0d actual %0d", $time, q_id[0], id);
        errors++;
      end
      if (key !== q_key[0]) begin
        $display("%0t: out_key expected %h actual %h", $time, q_key[0], key);
        errors++;
      end
      if (cnt !== q_cnt[0]) begin
        $display("%0t: item_count expected %0d actual %0d", $time, q_cnt[0], cnt);
        errors++;
      end
      if (emp !== q_emp[0]) begin
        $display("%0t: is_empty expected %0d actual %0d", $time, q_emp[0], emp);
        errors++;
      end
      if (err !== q_err[0]) begin
        $display("%0t: error_code expected %0d actual %0d", $time, q_err[0], err);
        errors++;
      end
      void'(q_id.pop_front());
      void'(q_key.pop_front());
      void'(q_cnt.pop_front());
      void'(q_emp.pop_front());
      void'(q_err.pop_front());
    endfunction

    function int pending();
      return q_id.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  imhq_req_if req ();
  imhq_rsp_if rsp ();

  indexed_min_heap_queue_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  heap_scoreboard board;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic [9:0]  live_ids [$];

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      board.check_result(rsp.out_id, rsp.out_key, rsp.item_count, rsp.is_empty,
                         rsp.error_code);
    end
    rsp.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_request(action_e act, logic [9:0] id, logic [31:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.item_id <= id;
    req.new_key <= key;
    do @(posedge clk_i); while (!req.ready);
    board.note_request(act, id, key);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [9:0]  id;
    logic [31:0] key;
    pick = $urandom_range(99);
    key = $urandom_range(3) == 0 ? $urandom : $urandom_range(255);
    if ($urandom_range(15) == 0) key = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    id = $urandom_range(1023);
    if (pick < 40) begin
      if (live_ids.size() > 0 && $urandom_range(9) == 0)
        id = live_ids[$urandom_range(live_ids.size() - 1)];
      send_request(ACT_INSERT, id, key);
    end else if (pick < 65) begin
      send_request(ACT_DELETE, id, key);
    end else if (pick < 90) begin
      if (board.held > 0 && $urandom_range(4) != 0) begin
        id = board.slot_id[$urandom_range(board.held - 1) + 1];
        if ($urandom_range(4) != 0) begin
          key = board.slot_key[board.pos_of[id]];
          key = $urandom_range(3) == 0 ? key : key - (key == 0 ? 0 : $urandom_range(key));
        end
      end
      send_request(ACT_DECREASE, id, key);
    end else begin
      send_request(ACT_PEEK, id, key);
    end
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.action = ACT_PEEK;
    req.item_id = '0;
    req.new_key = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(ACT_DELETE, 10'd5, 32'd0);
    send_request(ACT_PEEK, 10'd0, 32'd0);
    send_request(ACT_DECREASE, 10'd3, 32'd0);
    send_request(ACT_INSERT, 10'd1023, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 10'd0, 32'h0001_0000);
    send_request(ACT_INSERT, 10'd0, 32'h5);
    send_request(ACT_INSERT, 10'd512, 32'h0001_0000);
    send_request(ACT_INSERT, 10'd341, 32'h0);
    send_request(ACT_DECREASE, 10'd1023, 32'hFFFF_FFFF);
    send_request(ACT_DECREASE, 10'd1023, 32'h0);
    send_request(ACT_DECREASE, 10'd0, 32'h0002_0000);
    send_request(ACT_DECREASE, 10'd682, 32'h1);
    send_request(ACT_PEEK, 10'd0, 32'd0);
    repeat (6) send_request(ACT_DELETE, 10'd0, 32'd0);

    for (int i = 0; i < 1024; i++)
      send_request(ACT_INSERT, 10'(i ^ 10'h2A5), $urandom);
    send_request(ACT_INSERT, 10'd7, 32'd0);
    send_request(ACT_INSERT, 10'd0, 32'd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 38 : (phase == 1 ? 76 : 0);
      recv_idle_pct = phase == 0 ? 76 : (phase == 1 ? 38 : 0);
      for (int n = 0; n < 150; n++) begin
        live_ids.delete();
        for (int s = 1; s <= board.held && s <= 8; s++) live_ids.push_back(board.slot_id[s]);
        random_request();
        if (n == 75) drain();
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/imhq_pkg.sv
rtl/core/imhq_if.sv
rtl/core/imhq_ram.sv
rtl/core/imhq_ctrl.sv
rtl/core/indexed_min_heap_queue_unit.sv
rtl/core/imhq_checker.sv
tb/indexed_min_heap_queue_unit_test.sv
